// ===== hdl/lse_pkg.sv =====
// Shared types, constants and the exp table for the log-sum-exp normalizer.
package lse_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PROB_W = 17;
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned Q30_W  = 31;
  localparam int unsigned TAB_N  = 21;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30 = 30'h2000_0000;
  localparam logic [15:0] LN2_Q16  = 16'd45426;

  // front-to-back queue entry
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } fq_word_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM_EXP,
    ST_LN_NORM,
    ST_LN_STEP,
    ST_P_RD,
    ST_P_EXP,
    ST_DIV_RD,
    ST_DIV_EXP,
    ST_DIV_RUN,
    ST_EMIT
  } be_state_t;

  // exp unit command/status
  typedef struct packed {
    logic        start;
    logic [37:0] span;
  } exp_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] result;
  } exp_sts_t;

  // K[b] = exp(-2^(b-16)) in Q1.30
  function automatic logic [30:0] k_tab(input logic [4:0] b);
    logic [30:0] k;
    begin
      unique case (b)
        5'd0:  k = 31'd1073725440;
        5'd1:  k = 31'd1073709056;
        5'd2:  k = 31'd1073676290;
        5'd3:  k = 31'd1073610760;
        5'd4:  k = 31'd1073479712;
        5'd5:  k = 31'd1073217664;
        5'd6:  k = 31'd1072693760;
        5'd7:  k = 31'd1071646719;
        5'd8:  k = 31'd1069555701;
        5'd9:  k = 31'd1065385899;
        5'd10: k = 31'd1057095000;
        5'd11: k = 31'd1040706261;
        5'd12: k = 31'd1008687096;
        5'd13: k = 31'd947573834;
        5'd14: k = 31'd836230973;
        5'd15: k = 31'd651257337;
        5'd16: k = 31'd395007542;
        5'd17: k = 31'd145315154;
        5'd18: k = 31'd19666268;
        5'd19: k = 31'd360200;
        5'd20: k = 31'd121;
        default: k = 31'd0;
      endcase
      return k;
    end
  endfunction

endpackage

// ===== hdl/lse_front.sv =====
// Front end: accept words and queue them toward the back end.
module lse_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_log_weight,
  input  logic               in_final_item,
  output logic               q_valid,
  output lse_pkg::fq_word_t  q_word,
  input  logic               q_pop
);
  import lse_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fq_word_t         mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push;

  assign in_stall = (cnt_r == AW'(0) + (AW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_word   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{value: in_log_weight, last: in_final_item};
    end
  end
endmodule

// ===== hdl/lse_exp.sv =====
// Iterative exp(-d) unit: steps through d one bit per cycle, with one table multiply per set bit.
module lse_exp (
  input  logic               clk,
  input  logic               rst_n,
  input  lse_pkg::exp_cmd_t  cmd,
  output lse_pkg::exp_sts_t  sts
);
  import lse_pkg::*;

  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [20:0] d_r, d_nxt;
  logic [4:0]  b_r, b_nxt;
  logic [30:0] r_r, r_nxt;
  logic [61:0] prod;

  assign prod = r_r * k_tab(b_r);
  assign sts  = '{busy: busy_r, done: done_r, result: r_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    d_nxt    = d_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    if (cmd.start) begin
      b_nxt = '0;
      r_nxt = ONE_Q30;
      d_nxt = cmd.span[20:0];
      if (cmd.span >= 38'(32'h0020_0000)) begin
        r_nxt    = '0;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (d_r[0]) begin
        r_nxt = 31'((prod + 62'(HALF_Q30)) >> 30);
      end
      d_nxt = d_r >> 1;
      b_nxt = b_r + 1'b1;
      if ((d_r >> 1) == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    d_r <= d_nxt;
    b_r <= b_nxt;
    r_r <= r_nxt;
  end
endmodule

// ===== hdl/lse_back.sv =====
// Back end: store values, sum exps, take the log, normalize and emit.
module lse_back #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lse_pkg::fq_word_t  q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        out_probability,
  output logic               out_final_result,
  output logic               out_overflowed
);
  import lse_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  be_state_t st_r, st_nxt;

  logic signed [31:0] store_r [MAX_ITEMS];
  logic signed [31:0] rd_r;
  logic [CW-1:0]      cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic signed [31:0] max_r, max_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   psum_r, psum_nxt;
  logic               drop_r, drop_nxt;
  logic [SUM_W-1:0]   m_r, m_nxt;
  logic [21:0]        l_r, l_nxt;
  logic [3:0]         lb_r, lb_nxt;
  // restoring divider: numerator p*65536 + psum/2 (47 bits)
  logic [46:0]        dq_r, dq_nxt;
  logic [SUM_W:0]     drem_r, drem_nxt;
  logic [5:0]         dcnt_r, dcnt_nxt;
  logic               ov_r, ov_nxt;
  logic [16:0]        oprob_r, oprob_nxt;
  logic               ofin_r, ofin_nxt, odrop_r, odrop_nxt;

  exp_cmd_t    ecmd;
  exp_sts_t    ests;
  logic [70:0] lprod;
  logic [39:0] lt;
  logic [SUM_W:0] dtry;
  logic [32:0] span;
  logic        we;
  logic [AW-1:0] waddr;

  lse_exp u_exp (.clk(clk), .rst_n(rst_n), .cmd(ecmd), .sts(ests));

  assign lprod = m_r[30:0] * k_tab({1'b0, lb_r});
  assign lt    = 40'((lprod + 71'(HALF_Q30)) >> 30);
  assign span  = 33'(max_r) - 33'(rd_r);
  assign dtry  = {drem_r[SUM_W-1:0], dq_r[46]} - {1'b0, psum_r};

  assign out_valid        = ov_r;
  assign out_probability  = oprob_r;
  assign out_final_result = ofin_r;
  assign out_overflowed   = odrop_r;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    psum_nxt  = psum_r;
    drop_nxt  = drop_r;
    m_nxt     = m_r;
    l_nxt     = l_r;
    lb_nxt    = lb_r;
    dq_nxt    = dq_r;
    drem_nxt  = drem_r;
    dcnt_nxt  = dcnt_r;
    ov_nxt    = ov_r;
    oprob_nxt = oprob_r;
    ofin_nxt  = ofin_r;
    odrop_nxt = odrop_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = cnt_r[AW-1:0];
    ecmd      = '{start: 1'b0, span: '0};
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      ST_LOAD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (cnt_r < CW'(MAX_ITEMS)) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            if (q_word.value > max_r) begin
              max_nxt = q_word.value;
            end
          end else begin
            drop_nxt = 1'b1;
          end
          if (q_word.last) begin
            idx_nxt = '0;
            sum_nxt = '0;
            st_nxt  = ST_SUM_RD;
          end
        end
      end
      ST_SUM_RD: begin
        if (idx_r == cnt_r) begin
          st_nxt = ST_LN_NORM;
          m_nxt  = sum_r;
          l_nxt  = '0;
          lb_nxt = 4'd15;
        end else begin
          st_nxt = ST_SUM_EXP;
        end
      end
      ST_SUM_EXP: begin
        ecmd = '{start: !ests.busy && !ests.done, span: 38'(span)};
        if (ests.done) begin
          sum_nxt = sum_r + SUM_W'(ests.result);
          idx_nxt = idx_r + 1'b1;
          st_nxt  = ST_SUM_RD;
        end
      end
      ST_LN_NORM: begin
        if (sum_r < SUM_W'(ONE_Q30)) begin
          l_nxt    = '0;
          idx_nxt  = '0;
          psum_nxt = '0;
          st_nxt   = ST_P_RD;
        end else if (m_r >= SUM_W'({ONE_Q30, 1'b0})) begin
          m_nxt = m_r >> 1;
          l_nxt = l_r + 22'(LN2_Q16);
        end else begin
          st_nxt = ST_LN_STEP;
        end
      end
      ST_LN_STEP: begin
        if (lt >= 40'(ONE_Q30)) begin
          m_nxt = lt;
          l_nxt = l_r + (22'd1 << lb_r);
        end
        lb_nxt = lb_r - 1'b1;
        if (lb_r == '0) begin
          idx_nxt  = '0;
          psum_nxt = '0;
          st_nxt   = ST_P_RD;
        end
      end
      ST_P_RD: begin
        if (idx_r == cnt_r) begin
          idx_nxt = '0;
          st_nxt  = ST_DIV_RD;
        end else begin
          st_nxt = ST_P_EXP;
        end
      end
      ST_P_EXP: begin
        ecmd = '{start: !ests.busy && !ests.done, span: 38'(span) + 38'(l_r)};
        if (ests.done) begin
          psum_nxt = psum_r + SUM_W'(ests.result);
          idx_nxt  = idx_r + 1'b1;
          st_nxt   = ST_P_RD;
        end
      end
      ST_DIV_RD: begin
        st_nxt = ST_DIV_EXP;
      end
      ST_DIV_EXP: begin
        ecmd = '{start: !ests.busy && !ests.done, span: 38'(span) + 38'(l_r)};
        if (ests.done) begin
          // numerator = p*65536 + psum/2
          dq_nxt   = {ests.result, 16'd0} + 47'(psum_r >> 1);
          drem_nxt = '0;
          dcnt_nxt = 6'd47;
          st_nxt   = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (dtry[SUM_W]) begin
          drem_nxt = {drem_r[SUM_W-1:0], dq_r[46]};
          dq_nxt   = {dq_r[45:0], 1'b0};
        end else begin
          drem_nxt = dtry;
          dq_nxt   = {dq_r[45:0], 1'b1};
        end
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == 6'd1) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oprob_nxt = (psum_r == '0) ? 17'd0 :
                      (dq_r > 47'd65536) ? 17'd65536 : 17'(dq_r);
          ofin_nxt  = (idx_r + 1'b1 == cnt_r);
          odrop_nxt = drop_r;
          idx_nxt   = idx_r + 1'b1;
          if (idx_r + 1'b1 == cnt_r) begin
            cnt_nxt  = '0;
            max_nxt  = 32'sh8000_0000;
            sum_nxt  = '0;
            drop_nxt = 1'b0;
            st_nxt   = ST_LOAD;
          end else begin
            st_nxt = ST_DIV_RD;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_LOAD;
      cnt_r   <= '0;
      max_r   <= 32'sh8000_0000;
      sum_r   <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
    end
    psum_r  <= psum_nxt;
    m_r     <= m_nxt;
    l_r     <= l_nxt;
    lb_r    <= lb_nxt;
    dq_r    <= dq_nxt;
    drem_r  <= drem_nxt;
    dcnt_r  <= dcnt_nxt;
    oprob_r <= oprob_nxt;
    ofin_r  <= ofin_nxt;
    odrop_r <= odrop_nxt;
  end

  // value store: one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= q_word.value;
    end
    rd_r <= store_r[idx_r[AW-1:0]];
  end
endmodule

// ===== hdl/log_sum_exp_normalizer.sv =====
// Top level of the log-sum-exp softmax normalizer.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_log_weight, in_final_item
//  out     | output    | out_valid, out_stall, out_probability, out_final_result,
//          |           | out_overflowed
//
// Words enter a four-deep queue at one per cycle while in_stall is low and load
// one per cycle while the back end is loading. A final word starts two exp passes
// over the store (per value: read, start, one step per distance bit, done), a log,
// then per result a read, an exp, a restoring division and an emit.
// Reset is synchronous, active low. out_stall holds the result register, and
// a full queue raises in_stall while the back end computes.
module log_sum_exp_normalizer #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_log_weight,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_probability,
  output logic        out_final_result,
  output logic        out_overflowed
);
  import lse_pkg::*;

  logic     q_valid, q_pop;
  fq_word_t q_word;

  // front: accept and buffer words
  lse_front #(.DEPTH(4)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_log_weight, .in_final_item,
    .q_valid, .q_word, .q_pop
  );

  // back: store, reduce, normalize, emit
  lse_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk, .rst_n, .q_valid, .q_word, .q_pop,
    .out_valid, .out_stall, .out_probability, .out_final_result, .out_overflowed
  );
endmodule

// ===== hdl/lse_checker.sv =====
// Port-level checks for the normalizer, bound to the top level.
module lse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] out_probability,
  input logic        out_final_result,
  input logic        out_overflowed
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_probability))
    else $error("stalled result changed");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= 17'd65536)
    else $error("probability above one");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind log_sum_exp_normalizer lse_checker u_chk (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the log-sum-exp softmax normalizer.
`timescale 1ns / 1ps
module testbench;
  import lse_pkg::*;

  localparam int unsigned CAP = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_log_weight;
  logic        in_final_item;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] out_probability;
  logic        out_final_result;
  logic        out_overflowed;

  typedef struct packed {
    logic [16:0] probability;
    logic        final_result;
    logic        overflowed;
  } prob_word_t;

  typedef struct {
    logic [31:0] weight;
    logic        fin;
    logic        has_exp;
    logic [16:0] prob;
  } stim_row_t;

  prob_word_t  prob_q[$];
  stim_row_t   stim_q[$];
  logic [16:0] typed_q[$];
  logic        typed_has_q[$];

  // predictor state
  logic signed [31:0] set_vals[CAP];
  int unsigned        set_cnt;
  logic signed [31:0] set_max;
  logic               set_drop;

  int  fail_cnt;
  bit  done_stim;
  bit  quiet;

  log_sum_exp_normalizer #(.MAX_ITEMS(CAP)) dut (.*);

  // clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] k_const(input int b);
    logic [63:0] k [21];
    k = '{64'd1073725440, 64'd1073709056, 64'd1073676290, 64'd1073610760,
          64'd1073479712, 64'd1073217664, 64'd1072693760, 64'd1071646719,
          64'd1069555701, 64'd1065385899, 64'd1057095000, 64'd1040706261,
          64'd1008687096, 64'd947573834, 64'd836230973, 64'd651257337,
          64'd395007542, 64'd145315154, 64'd19666268, 64'd360200, 64'd121};
    return k[b];
  endfunction

  // exp(-d), d in Q16.16, result in Q30
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] d);
    logic [63:0] r;
    r = 64'd1 << 30;
    if (d >= (64'd32 << 16)) return 64'd0;
    for (int b = 0; b < 21; b++)
      if (d[b]) r = (r * k_const(b) + (64'd1 << 29)) >> 30;
    return r;
  endfunction

  // ln(s), s in Q30 >= 1.0, result in Q16.16
  function automatic logic [63:0] ln_q16(input logic [63:0] s);
    logic [63:0] m;
    logic [63:0] l;
    logic [63:0] t;
    int k;
    m = s;
    k = 0;
    while (m >= (64'd1 << 31) && k < 40) begin
      m = m >> 1;
      k++;
    end
    l = k * 64'd45426;
    for (int b = 15; b >= 0; b--) begin
      t = (m * k_const(b) + (64'd1 << 29)) >> 30;
      if (t >= (64'd1 << 30)) begin
        m = t;
        l += 64'd1 << b;
      end
    end
    return l;
  endfunction

  // take one accepted word; on a final word queue every probability of the set
  task automatic predict_word(input logic [31:0] w, input logic fin);
    logic [63:0] esum;
    logic [63:0] lsum;
    logic [63:0] psum;
    logic [63:0] pr[CAP];
    logic [63:0] p;
    logic [63:0] span;
    prob_word_t  pw;
    if (set_cnt < CAP) begin
      set_vals[set_cnt] = w;
      set_cnt++;
      if ($signed(w) > set_max) set_max = w;
    end else begin
      set_drop = 1'b1;
    end
    if (!fin) return;
    esum = 0;
    for (int i = 0; i < set_cnt; i++) begin
      span = 64'(longint'(set_max) - longint'(set_vals[i]));
      esum += exp_neg_q30(span);
    end
    esum &= 64'hFF_FFFF_FFFF;
    lsum = (esum >= (64'd1 << 30)) ? ln_q16(esum) : 64'd0;
    psum = 0;
    for (int i = 0; i < set_cnt; i++) begin
      span = 64'(longint'(set_max) - longint'(set_vals[i]));
      pr[i] = exp_neg_q30(span + lsum);
      psum += pr[i];
    end
    for (int i = 0; i < set_cnt; i++) begin
      p = 0;
      if (psum != 0) begin
        p = (pr[i] * 64'd65536 + psum / 2) / psum;
        if (p > 64'd65536) p = 64'd65536;
      end
      pw.probability  = p[16:0];
      pw.final_result = (i + 1 == set_cnt);
      pw.overflowed   = set_drop;
      prob_q = {prob_q, pw};
    end
    set_cnt  = 0;
    set_max  = 32'sh8000_0000;
    set_drop = 1'b0;
  endtask

  task automatic add_row(input logic [31:0] w, input logic fin,
                         input logic has, input logic [16:0] pr);
    stim_row_t r;
    r.weight  = w;
    r.fin     = fin;
    r.has_exp = has;
    r.prob    = pr;
    stim_q = {stim_q, r};
  endtask

  // directed table, then well-formed random sets with a little noise
  task automatic build_stimulus();
    int total;
    int len;
    int mode;
    logic [31:0] w;
    // single value set: always 1.0
    add_row(32'h0000_0000, 1'b1, 1'b1, 17'd65536);
    add_row(32'h7FFF_FFFF, 1'b1, 1'b1, 17'd65536);
    add_row(32'h8000_0000, 1'b1, 1'b1, 17'd65536);
    // extremes in one set: the minimum is too far away to count
    add_row(32'h8000_0000, 1'b0, 1'b1, 17'd0);
    add_row(32'h7FFF_FFFF, 1'b1, 1'b1, 17'd65536);
    // equal pair
    add_row(32'h0001_0000, 1'b0, 1'b0, 17'd0);
    add_row(32'h0001_0000, 1'b1, 1'b0, 17'd0);
    // distance exactly 32.0 and just under
    add_row(32'h0000_0000, 1'b0, 1'b0, 17'd0);
    add_row(32'h0020_0000, 1'b0, 1'b0, 17'd0);
    add_row(32'h0000_0001, 1'b1, 1'b0, 17'd0);
    // widely spread alternating bit patterns
    add_row(32'hAAAA_AAAA, 1'b0, 1'b0, 17'd0);
    add_row(32'h5555_5555, 1'b0, 1'b0, 17'd0);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 17'd0);
    total = stim_q.size();
    // full store with drops, ended by a final word that is itself dropped
    for (int i = 0; i < CAP + 3; i++) begin
      w = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      add_row(w, i == CAP + 2, 1'b0, 17'd0);
    end
    // random sets: mostly short, a few long
    total = 0;
    while (total < 110) begin
      mode = $urandom_range(0, 9);
      len = (mode == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (mode == 1) w = $urandom();
        else w = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        add_row(w, i == len - 1, 1'b0, 17'd0);
        total++;
      end
    end
  endtask

  // source: drive at the falling edge, advance when accepted
  initial begin
    stim_row_t cur;
    int gap;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_log_weight = '0;
    in_final_item = 1'b0;
    out_stall     = 1'b0;
    fail_cnt      = 0;
    done_stim     = 1'b0;
    quiet         = 1'b0;
    set_cnt       = 0;
    set_max       = 32'sh8000_0000;
    set_drop      = 1'b0;
    build_stimulus();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int idx = 0; idx < stim_q.size(); idx++) begin
      cur = stim_q[idx];
      if (idx > stim_q.size() - 40) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid      = 1'b1;
      in_log_weight = cur.weight;
      in_final_item = cur.fin;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      predict_word(cur.weight, cur.fin);
      if (cur.fin) begin
        typed_has_q = {typed_has_q, cur.has_exp};
        typed_q     = {typed_q, cur.prob};
      end
      @(negedge clk);
    end
    in_valid  = 1'b0;
    done_stim = 1'b1;
  end

  // sink stall: random bursts, none near the end
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    prob_word_t want;
    logic       typed_has;
    logic [16:0] typed_val;
    if (rst_n && out_valid && !out_stall) begin
      if (prob_q.size() == 0) begin
        $error("unexpected result: probability %0d", out_probability);
        fail_cnt++;
      end else begin
        want = prob_q.pop_front();
        if (out_probability !== want.probability) begin
          $error("probability: expected %0d, got %0d", want.probability, out_probability);
          fail_cnt++;
        end
        if (out_final_result !== want.final_result) begin
          $error("final_result: expected %0d, got %0d", want.final_result,
                 out_final_result);
          fail_cnt++;
        end
        if (out_overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, got %0d", want.overflowed, out_overflowed);
          fail_cnt++;
        end
        // typed values apply to the final result of each set, checked where the row has one
        if (want.final_result && typed_q.size() > 0) begin
          typed_has = typed_has_q.pop_front();
          typed_val = typed_q.pop_front();
          if (typed_has && out_probability !== typed_val) begin
            $error("probability: expected %0d, got %0d", typed_val, out_probability);
            fail_cnt++;
          end
        end
      end
    end
  end

  // drain, settle, report
  initial begin
    wait (done_stim);
    while (prob_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && prob_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // timeout
  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
